[hdl/tacs_pkg.sv]
package tacs_pkg;

  typedef logic [7:0] byte_t;

  // Opcodes live in the top three bits of an instruction byte.
  localparam logic [2:0] OP_BR  = 3'd0;
  localparam logic [2:0] OP_BZ  = 3'd1;
  localparam logic [2:0] OP_LDI = 3'd2;
  localparam logic [2:0] OP_LIM = 3'd3;
  localparam logic [2:0] OP_ST  = 3'd4;
  localparam logic [2:0] OP_ADD = 3'd5;
  localparam logic [2:0] OP_NOP = 3'd6;
  localparam logic [2:0] OP_HLT = 3'd7;

  localparam logic OPER_LOAD = 1'b0;
  localparam logic OPER_STEP = 1'b1;

  typedef struct packed {
    logic  en;
    byte_t addr;
    byte_t data;
  } wr_t;

  typedef struct packed {
    byte_t            pc;
    logic [3:0][7:0]  regs;
    logic             halted;
  } arch_t;

  function automatic byte_t sext5(input byte_t ins);
    return {{3{ins[4]}}, ins[4:0]};
  endfunction

endpackage

[hdl/tacs_mem.sv]
module tacs_mem (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tacs_pkg::wr_t        wr,
  input  tacs_pkg::byte_t      ra_addr,
  input  tacs_pkg::byte_t      rb_addr,
  output tacs_pkg::byte_t      ra_data_r,
  output tacs_pkg::byte_t      rb_data_r
);

  tacs_pkg::byte_t mem_r [256];
  logic [255:0]    valid_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_r[wr.addr] <= wr.data;
    end
  end

  // Entries never written since reset read as zero. Both ports return the
  // word being written in the same cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      ra_data_r <= '0;
      rb_data_r <= '0;
    end else begin
      if (wr.en) begin
        valid_r[wr.addr] <= 1'b1;
      end
      if (wr.en && wr.addr == ra_addr) begin
        ra_data_r <= wr.data;
      end else begin
        ra_data_r <= valid_r[ra_addr] ? mem_r[ra_addr] : '0;
      end
      if (wr.en && wr.addr == rb_addr) begin
        rb_data_r <= wr.data;
      end else begin
        rb_data_r <= valid_r[rb_addr] ? mem_r[rb_addr] : '0;
      end
    end
  end

endmodule

[hdl/tacs_exec.sv]
module tacs_exec (
  input  tacs_pkg::arch_t  cur,
  input  tacs_pkg::byte_t  ir,
  input  tacs_pkg::byte_t  ld_data,
  input  logic             operation,
  input  tacs_pkg::byte_t  address,
  input  tacs_pkg::byte_t  data,
  output tacs_pkg::arch_t  nxt,
  output tacs_pkg::wr_t    wr
);

  logic [2:0]      opc;
  logic [1:0]      s_sel;
  logic [1:0]      r_sel;
  tacs_pkg::byte_t pc_inc;
  tacs_pkg::byte_t pc_br;

  assign opc    = ir[7:5];
  assign s_sel  = ir[3:2];
  assign r_sel  = ir[1:0];
  assign pc_inc = cur.pc + 8'd1;
  assign pc_br  = pc_inc + tacs_pkg::sext5(ir);

  always_comb begin
    nxt     = cur;
    wr.en   = 1'b0;
    wr.addr = address;
    wr.data = data;
    if (operation == tacs_pkg::OPER_LOAD) begin
      wr.en = 1'b1;
    end else if (!cur.halted) begin
      nxt.pc = pc_inc;
      case (opc)
        tacs_pkg::OP_BR: begin
          nxt.pc = pc_br;
        end
        tacs_pkg::OP_BZ: begin
          if (cur.regs[1] == '0) begin
            nxt.pc = pc_br;
          end
        end
        tacs_pkg::OP_LDI: begin
          nxt.regs[r_sel] = ld_data;
        end
        tacs_pkg::OP_LIM: begin
          nxt.regs[0] = tacs_pkg::sext5(ir);
        end
        tacs_pkg::OP_ST: begin
          wr.en   = 1'b1;
          wr.addr = cur.regs[s_sel];
          wr.data = cur.regs[r_sel];
        end
        tacs_pkg::OP_ADD: begin
          nxt.regs[r_sel] = cur.regs[r_sel] + cur.regs[s_sel];
        end
        tacs_pkg::OP_HLT: begin
          nxt.halted = 1'b1;
          nxt.pc     = cur.pc;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

[hdl/tiny_accumulator_cpu_step.sv]
// Latency: a result is valid in the cycle after its word is accepted.
// Throughput: one word per cycle unless out_ready stalls a result; while the pc
// holds an indirect load and the processor is not halted, a word that directly
// follows an accepted word waits for the second read port of the 256-byte memory.
// Reset (synchronous, active low) clears the registers, pc and halt flag and
// marks every memory byte unwritten so that it reads as zero; no clearing pass.
module tiny_accumulator_cpu_step (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_operation,
  input  logic [7:0] in_address,
  input  logic [7:0] in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_pc,
  output logic [7:0] out_reg0,
  output logic [7:0] out_reg1,
  output logic [7:0] out_reg2,
  output logic [7:0] out_reg3,
  output logic       out_halted
);

  tacs_pkg::arch_t arch_r;
  tacs_pkg::arch_t arch_nxt;
  tacs_pkg::arch_t exe_nxt;
  tacs_pkg::wr_t   exe_wr;
  tacs_pkg::wr_t   mem_wr;
  tacs_pkg::byte_t ir_r;
  tacs_pkg::byte_t ld_data_r;
  tacs_pkg::byte_t rb_addr;
  logic            out_valid_r;
  logic            out_valid_nxt;
  logic            bok_r;
  logic            accept;
  logic            ldi_wait;

  // ir_r always holds the byte at the current pc. The second port reads
  // at the address the current instruction would use; that word is only
  // trusted when bok_r shows that no word was accepted as it was read.
  assign ldi_wait = (ir_r[7:5] == tacs_pkg::OP_LDI) && !arch_r.halted && !bok_r;
  assign in_ready = rst_n && (!out_valid_r || out_ready) && !ldi_wait;
  assign accept   = in_valid && in_ready;

  tacs_exec u_exec (
    .cur       (arch_r),
    .ir        (ir_r),
    .ld_data   (ld_data_r),
    .operation (in_operation),
    .address   (in_address),
    .data      (in_data),
    .nxt       (exe_nxt),
    .wr        (exe_wr)
  );

  always_comb begin
    mem_wr        = exe_wr;
    mem_wr.en     = exe_wr.en && accept;
    arch_nxt      = accept ? exe_nxt : arch_r;
    out_valid_nxt = accept || (out_valid_r && !out_ready);
  end

  assign rb_addr = arch_r.regs[ir_r[3:2]];

  tacs_mem u_mem (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr        (mem_wr),
    .ra_addr   (arch_nxt.pc),
    .rb_addr   (rb_addr),
    .ra_data_r (ir_r),
    .rb_data_r (ld_data_r)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arch_r      <= '0;
      out_valid_r <= 1'b0;
      bok_r       <= 1'b0;
    end else begin
      arch_r      <= arch_nxt;
      out_valid_r <= out_valid_nxt;
      bok_r       <= !accept;
    end
  end

  // The architectural state only moves on acceptance, which needs the
  // result slot free, so it doubles as the result register.
  assign out_valid  = out_valid_r;
  assign out_pc     = arch_r.pc;
  assign out_reg0   = arch_r.regs[0];
  assign out_reg1   = arch_r.regs[1];
  assign out_reg2   = arch_r.regs[2];
  assign out_reg3   = arch_r.regs[3];
  assign out_halted = arch_r.halted;

`ifndef SYNTHESIS
  a_halt_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    arch_r.halted |=> arch_r.halted)
    else $error("halt flag cleared without reset");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted word produced no result");

  a_load_keeps_pc: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_operation == tacs_pkg::OPER_LOAD) |=> $stable(arch_r.pc))
    else $error("memory load changed the program counter");

  a_ldi_data_fresh: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_operation == tacs_pkg::OPER_STEP && !arch_r.halted
     && ir_r[7:5] == tacs_pkg::OP_LDI) |-> bok_r)
    else $error("indirect load executed with stale read data");
`endif

endmodule
